// File: hw/rtl/rspf_pkg.sv
`default_nettype none
package rspf_pkg;
    localparam int MAX_RECORD_BYTES = 4096;
    localparam int POS_W = $clog2(MAX_RECORD_BYTES + 1);
    localparam int VALUE_STRING_BYTES = 16;

    localparam logic [1:0] TYPE_INT   = 2'd0;
    localparam logic [1:0] TYPE_FLOAT = 2'd1;
    localparam logic [1:0] TYPE_STR   = 2'd2;

    localparam logic [2:0] OP_EQ  = 3'd0;
    localparam logic [2:0] OP_NE  = 3'd1;
    localparam logic [2:0] OP_GT  = 3'd2;
    localparam logic [2:0] OP_GE  = 3'd3;
    localparam logic [2:0] OP_LT  = 3'd4;
    localparam logic [2:0] OP_LE  = 3'd5;
    localparam logic [2:0] OP_ALL = 3'd6;

    localparam logic [2:0] REG_TYPE  = 3'd0;
    localparam logic [2:0] REG_OP    = 3'd1;
    localparam logic [2:0] REG_OFS   = 3'd2;
    localparam logic [2:0] REG_LEN   = 3'd3;
    localparam logic [2:0] REG_VLOW  = 3'd4;
    localparam logic [2:0] REG_VHIGH = 3'd5;

    typedef enum logic [1:0] {
        REL_EQUAL   = 2'd0,
        REL_LESS    = 2'd1,
        REL_GREATER = 2'd2
    } t_rel;

    typedef struct packed {
        logic [1:0]   field_type;
        logic [2:0]   compare_op;
        logic [11:0]  field_offset;
        logic [7:0]   field_length;
        logic [127:0] value;
    } t_cfg;

    // state at the end of a slot, handed to the result stage
    typedef struct packed {
        logic        empty;
        logic        complete;
        logic [31:0] gather;
        logic        str_decided;
        t_rel        str_rel;
    } t_slot_end;

    function automatic logic op_apply(input logic [2:0] op, input t_rel rel);
        logic r;
        case (op)
            OP_EQ:   r = (rel == REL_EQUAL);
            OP_NE:   r = (rel != REL_EQUAL);
            OP_GT:   r = (rel == REL_GREATER);
            OP_GE:   r = (rel != REL_LESS);
            OP_LT:   r = (rel == REL_LESS);
            OP_LE:   r = (rel != REL_GREATER);
            default: r = 1'b1;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] value_byte(input logic [127:0] v, input logic [8:0] i);
        logic [7:0] r;
        if (i >= 9'(VALUE_STRING_BYTES)) r = 8'd0;
        else r = v[i[3:0]*8 +: 8];
        return r;
    endfunction
endpackage
`default_nettype wire

// File: hw/rtl/rspf_scan.sv
`default_nettype none
module rspf_scan
    import rspf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_take,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_empty,
    input  wire logic       i_last,
    output t_slot_end       o_end,
    output logic            o_end_valid
);
    logic [POS_W-1:0] r_pos, n_pos;
    logic [31:0] r_gather, n_gather;
    logic r_decided, n_decided;
    t_rel r_rel, n_rel;
    logic [8:0] len;
    logic [POS_W:0] idx_full;
    logic [8:0] idx;
    logic in_field;
    logic [7:0] vb;

    always_comb begin
        len = (i_cfg.field_type == TYPE_STR) ? {1'b0, i_cfg.field_length} : 9'd4;
        idx_full = {1'b0, r_pos} - (POS_W+1)'(i_cfg.field_offset);
        idx = idx_full[8:0];
        in_field = (r_pos < POS_W'(MAX_RECORD_BYTES)) && (r_pos >= POS_W'(i_cfg.field_offset))
                   && (idx_full < (POS_W+1)'(len));
        vb = value_byte(i_cfg.value, idx);
        n_pos = r_pos;
        n_gather = r_gather;
        n_decided = r_decided;
        n_rel = r_rel;
        if (r_pos < POS_W'(MAX_RECORD_BYTES)) n_pos = r_pos + 1'b1;
        if (in_field) begin
            if (i_cfg.field_type == TYPE_STR) begin
                if (!r_decided) begin
                    if (i_byte == 8'd0) begin
                        n_rel = (vb != 8'd0) ? REL_LESS : REL_EQUAL;
                        n_decided = 1'b1;
                    end else if (vb == 8'd0 || i_byte > vb) begin
                        n_rel = REL_GREATER;
                        n_decided = 1'b1;
                    end else if (i_byte < vb) begin
                        n_rel = REL_LESS;
                        n_decided = 1'b1;
                    end
                end
            end else if (idx < 9'd4) begin
                n_gather[idx[1:0]*8 +: 8] = r_gather[idx[1:0]*8 +: 8] | i_byte;
            end
        end
        o_end.empty = i_empty;
        o_end.complete = ({1'b0, n_pos} >= ((POS_W+1)'(i_cfg.field_offset) + (POS_W+1)'(len)));
        o_end.gather = n_gather;
        o_end.str_decided = n_decided;
        o_end.str_rel = n_rel;
        o_end_valid = i_take && i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_gather <= '0;
            r_decided <= 1'b0;
            r_rel <= REL_EQUAL;
        end else if (i_take) begin
            if (i_last) begin
                r_pos <= '0;
                r_gather <= '0;
                r_decided <= 1'b0;
                r_rel <= REL_EQUAL;
            end else begin
                r_pos <= n_pos;
                r_gather <= n_gather;
                r_decided <= n_decided;
                r_rel <= n_rel;
            end
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/rspf_judge.sv
`default_nettype none
module rspf_judge
    import rspf_pkg::*;
(
    input  wire t_cfg      i_cfg,
    input  wire t_slot_end i_end,
    output logic           o_match
);
    logic [31:0] a, c;
    logic a_nan, c_nan, a_z, c_z;
    logic f_lt, f_eq;
    t_rel irel, srel;
    logic pred;

    always_comb begin
        a = i_end.gather;
        c = i_cfg.value[31:0];
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 0);
        c_nan = (c[30:23] == 8'hFF) && (c[22:0] != 0);
        a_z = (a[30:0] == 0);
        c_z = (c[30:0] == 0);
        // sign-magnitude ordering, both zeros equal
        f_eq = (a == c) || (a_z && c_z);
        if (f_eq) f_lt = 1'b0;
        else if (a[31] != c[31]) f_lt = a[31];
        else if (a[31]) f_lt = a[30:0] > c[30:0];
        else f_lt = a[30:0] < c[30:0];
        if ((a ^ 32'h8000_0000) < (c ^ 32'h8000_0000)) irel = REL_LESS;
        else if (a == c) irel = REL_EQUAL;
        else irel = REL_GREATER;
        if (i_end.str_decided) srel = i_end.str_rel;
        else srel = (value_byte(i_cfg.value, {1'b0, i_cfg.field_length}) != 8'd0)
                    ? REL_LESS : REL_EQUAL;
        if (i_cfg.compare_op >= OP_ALL) pred = 1'b1;
        else if (i_cfg.field_type == TYPE_FLOAT) begin
            if (a_nan || c_nan) pred = (i_cfg.compare_op == OP_NE);
            else pred = op_apply(i_cfg.compare_op,
                                 f_eq ? REL_EQUAL : (f_lt ? REL_LESS : REL_GREATER));
        end else if (i_cfg.field_type == TYPE_STR) pred = op_apply(i_cfg.compare_op, srel);
        else pred = op_apply(i_cfg.compare_op, irel);
        o_match = !i_end.empty && i_end.complete && pred;
    end
endmodule
`default_nettype wire

// File: hw/rtl/record_scan_predicate_filter_core.sv
`default_nettype none
// record scan selection filter
// slave stream: one record byte per item, tdata = data_byte, tuser = slot_empty,
// tlast marks the last byte of a slot. the attribute at the configured offset is
// compared with the configured value; on each last byte one result item leaves
// the master stream: tdata = {field_incomplete, slot_ordinal, record_match}.
// throughput is one byte per cycle while s_axis_tready is high; a result appears in
// the cycle after its last byte is taken. bytes are folded into running state the cycle
// they arrive, so the judge logic sits between that state and the output register.
// a stalled output register holds its result; s_axis_tready drops only while a
// result waits and a new last byte would need the register, so other bytes keep
// flowing. reset clears position, gathered bytes, slot counter and registers to
// type integer, op always-true, offset 0, length 4, value 0. configuration is written
// through i_cfg_we / i_cfg_idx / i_cfg_data; the user must do so only while idle, unenforced.
module record_scan_predicate_filter_core
    import rspf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tuser,   // slot_empty
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // record_match, slot_ordinal[32], field_incomplete
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data
);
    t_cfg r_cfg;
    t_slot_end slot_end;
    logic end_valid, take, match;
    logic r_valid;
    logic [31:0] r_count;
    logic [39:0] r_data;

    assign s_axis_tready = !r_valid || m_axis_tready || !s_axis_tlast;
    assign take = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.field_type <= TYPE_INT;
            r_cfg.compare_op <= OP_ALL;
            r_cfg.field_offset <= '0;
            r_cfg.field_length <= 8'd4;
            r_cfg.value <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TYPE:  r_cfg.field_type <= i_cfg_data[1:0];
                REG_OP:    r_cfg.compare_op <= i_cfg_data[2:0];
                REG_OFS:   r_cfg.field_offset <= i_cfg_data[11:0];
                REG_LEN:   r_cfg.field_length <= i_cfg_data[7:0];
                REG_VLOW:  r_cfg.value[63:0] <= i_cfg_data;
                REG_VHIGH: r_cfg.value[127:64] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rspf_scan u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_take(take),
        .i_byte(s_axis_tdata), .i_empty(s_axis_tuser), .i_last(s_axis_tlast),
        .o_end(slot_end), .o_end_valid(end_valid)
    );

    rspf_judge u_judge (.i_cfg(r_cfg), .i_end(slot_end), .o_match(match));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            if (end_valid) begin
                r_valid <= 1'b1;
                r_count <= r_count + 1'b1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
        if (end_valid) r_data <= {6'd0, !slot_end.complete, r_count, match};
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata = r_data;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !end_valid) else $error("result lost");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        end_valid |=> r_count == $past(r_count) + 32'd1) else $error("ordinal skip");
    a_incomplete_nomatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[33]) |-> !m_axis_tdata[0]) else $error("bad match");
`endif
endmodule
`default_nettype wire

// File: dv/rspf_checker.sv
`timescale 1ns / 1ps
module rspf_checker
    import rspf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,
    input  wire logic        s_axis_tuser,
    input  wire logic        s_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);
    typedef struct {
        logic        hit;
        logic [31:0] ordinal;
        logic        incomplete;
    } t_verdict;

    t_verdict verdict_q[$];

    logic [1:0]   ftype;
    logic [2:0]   cmp_op;
    logic [11:0]  fofs;
    logic [7:0]   flen;
    logic [127:0] cvalue;

    int          pos;
    logic [31:0] gather;
    logic        decided;
    t_rel        rel;
    logic [31:0] slot_count;

    assign o_pending = verdict_q.size();

    function automatic logic [7:0] cmp_byte(input int i);
        return (i < VALUE_STRING_BYTES) ? cvalue[i*8 +: 8] : 8'd0;
    endfunction

    function automatic logic rel_holds(input t_rel r);
        case (cmp_op)
            OP_EQ:   return r == REL_EQUAL;
            OP_NE:   return r != REL_EQUAL;
            OP_GT:   return r == REL_GREATER;
            OP_GE:   return r != REL_LESS;
            OP_LT:   return r == REL_LESS;
            OP_LE:   return r != REL_GREATER;
            default: return 1'b1;
        endcase
    endfunction

    // monotonic key for ordered floats, both zeros map to the same key
    function automatic logic [31:0] float_key(input logic [31:0] f);
        if (f[30:0] == 31'd0) return 32'h8000_0000;
        return f[31] ? ~f : (f | 32'h8000_0000);
    endfunction

    function automatic logic attr_holds();
        logic [31:0] a;
        logic [31:0] c;
        t_rel r;
        if (cmp_op >= OP_ALL) return 1'b1;
        if (ftype == TYPE_FLOAT) begin
            if ((gather[30:23] == 8'hff && gather[22:0] != 0) ||
                (cvalue[30:23] == 8'hff && cvalue[22:0] != 0))
                return cmp_op == OP_NE;
            a = float_key(gather);
            c = float_key(cvalue[31:0]);
        end else if (ftype == TYPE_STR) begin
            r = rel;
            if (!decided) r = (cmp_byte(flen) != 0) ? REL_LESS : REL_EQUAL;
            return rel_holds(r);
        end else begin
            a = gather ^ 32'h8000_0000;
            c = cvalue[31:0] ^ 32'h8000_0000;
        end
        r = (a < c) ? REL_LESS : ((a > c) ? REL_GREATER : REL_EQUAL);
        return rel_holds(r);
    endfunction

    task automatic take_byte(input logic [7:0] b, input logic empty, input logic last);
        int alen;
        int i;
        logic [7:0] v;
        logic done;
        t_verdict e;
        alen = (ftype == TYPE_STR) ? int'(flen) : 4;
        if (pos < MAX_RECORD_BYTES) begin
            if (pos >= fofs && pos - fofs < alen) begin
                i = pos - fofs;
                if (ftype == TYPE_STR) begin
                    if (!decided) begin
                        v = cmp_byte(i);
                        if (b == 0) begin
                            rel = (v != 0) ? REL_LESS : REL_EQUAL;
                            decided = 1'b1;
                        end else if (v == 0 || b > v) begin
                            rel = REL_GREATER;
                            decided = 1'b1;
                        end else if (b < v) begin
                            rel = REL_LESS;
                            decided = 1'b1;
                        end
                    end
                end else if (i < 4) begin
                    gather[i*8 +: 8] = b;
                end
            end
            pos++;
        end
        if (last) begin
            done = pos >= int'(fofs) + alen;
            e.hit = !empty && done && attr_holds();
            e.ordinal = slot_count;
            e.incomplete = !done;
            verdict_q.push_back(e);
            slot_count++;
            pos = 0;
            gather = '0;
            decided = 1'b0;
            rel = REL_EQUAL;
        end
    endtask

    always @(posedge i_clk) begin
        t_verdict e;
        if (!i_rst_n) begin
            ftype = TYPE_INT;
            cmp_op = OP_ALL;
            fofs = '0;
            flen = 8'd4;
            cvalue = '0;
            pos = 0;
            gather = '0;
            decided = 1'b0;
            rel = REL_EQUAL;
            slot_count = '0;
            verdict_q.delete();
            o_fail_count = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result item %h", $time, m_axis_tdata);
                    o_fail_count++;
                end else begin
                    e = verdict_q.pop_front();
                    if (m_axis_tdata[0] !== e.hit || m_axis_tdata[32:1] !== e.ordinal ||
                        m_axis_tdata[33] !== e.incomplete || m_axis_tdata[39:34] !== 6'd0) begin
                        $display("%0t: mismatch expected match=%0b ordinal=%0d incomplete=%0b",
                                 $time, e.hit, e.ordinal, e.incomplete);
                        $display("%0t:          actual   match=%0b ordinal=%0d incomplete=%0b pad=%h",
                                 $time, m_axis_tdata[0], m_axis_tdata[32:1], m_axis_tdata[33],
                                 m_axis_tdata[39:34]);
                        o_fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                take_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            // a write lands after the byte of the same edge
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TYPE:  ftype = i_cfg_data[1:0];
                    REG_OP:    cmp_op = i_cfg_data[2:0];
                    REG_OFS:   fofs = i_cfg_data[11:0];
                    REG_LEN:   flen = i_cfg_data[7:0];
                    REG_VLOW:  cvalue[63:0] = i_cfg_data;
                    REG_VHIGH: cvalue[127:64] = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
    import rspf_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // data_byte
    logic        s_axis_tuser = 1'b0; // slot_empty
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // record_match, slot_ordinal[32], field_incomplete
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold = 1'b0;

    logic [1:0]   cur_type = TYPE_INT;
    logic [7:0]   cur_len = 8'd4;
    logic [11:0]  cur_ofs = '0;
    logic [127:0] cur_value = '0;
    logic [7:0]   attr_bytes [0:255];

    always #5 i_clk = ~i_clk;

    record_scan_predicate_filter_core dut (.*);

    rspf_checker u_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .s_axis_tlast, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .i_cfg_we,
        .i_cfg_idx, .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(negedge i_clk)
        m_axis_tready <= !hold && ($urandom_range(0, 99) >= recv_stall_pct);

    // long output hold-off so the input side backs up
    initial begin
        wait (hold_req);
        hold = 1'b1;
        repeat (300) @(posedge i_clk);
        hold = 1'b0;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic empty, input logic last);
        @(negedge i_clk);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata = 8'($urandom);
            do @(negedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = b;
        s_axis_tuser = empty;
        s_axis_tlast = last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        wait (pending == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input logic [1:0] ft, input logic [2:0] op,
                             input logic [11:0] ofs, input logic [7:0] len,
                             input logic [127:0] v);
        drain();
        write_reg(REG_TYPE, 64'(ft));
        write_reg(REG_OP, 64'(op));
        write_reg(REG_OFS, 64'(ofs));
        write_reg(REG_LEN, 64'(len));
        write_reg(REG_VLOW, v[63:0]);
        write_reg(REG_VHIGH, v[127:64]);
        cur_type = ft;
        cur_ofs = ofs;
        cur_len = len;
        cur_value = v;
    endtask

    function automatic logic [31:0] pick_number(input logic [31:0] near);
        case ($urandom_range(0, 9))
            0: return near;
            1: return near + 1;
            2: return near - 1;
            3: return 32'h7fc0_0000;
            4: return 32'h8000_0000;
            5: return 32'h0000_0000;
            6: return 32'h7fff_ffff;
            7: return 32'hff80_0000;
            8: return {near[31:23], 23'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [127:0] pick_value(input logic [1:0] ft);
        logic [127:0] v;
        int n;
        v = '0;
        if (ft == TYPE_STR) begin
            n = $urandom_range(0, 17);
            for (int i = 0; i < 16; i++)
                if (i < n) v[i*8 +: 8] = 8'($urandom_range(1, 255));
        end else begin
            v = {$urandom, $urandom, $urandom, pick_number($urandom)};
        end
        return v;
    endfunction

    task automatic fill_attr();
        logic [31:0] num;
        logic [7:0] vb;
        int k;
        if (cur_type == TYPE_STR) begin
            k = $urandom_range(0, int'(cur_len));
            for (int i = 0; i < 256; i++) begin
                vb = (i < 16) ? cur_value[i*8 +: 8] : 8'd0;
                if (i < k) attr_bytes[i] = vb;
                else case ($urandom_range(0, 3))
                    0: attr_bytes[i] = 8'd0;
                    1: attr_bytes[i] = vb + 8'd1;
                    2: attr_bytes[i] = vb - 8'd1;
                    default: attr_bytes[i] = 8'($urandom);
                endcase
            end
        end else begin
            num = pick_number(cur_value[31:0]);
            for (int i = 0; i < 4; i++) attr_bytes[i] = num[i*8 +: 8];
        end
    endtask

    task automatic send_record(input int len, input logic empty, input logic noisy);
        int alen;
        logic [7:0] b;
        alen = (cur_type == TYPE_STR) ? int'(cur_len) : 4;
        fill_attr();
        for (int j = 0; j < len; j++) begin
            b = 8'($urandom);
            if (j >= cur_ofs && j - cur_ofs < alen) b = attr_bytes[j - cur_ofs];
            send_byte(b, (j == len - 1 || !noisy) ? empty : logic'($urandom), j == len - 1);
        end
    endtask

    task automatic random_record(output int len);
        int need;
        need = int'(cur_ofs) + ((cur_type == TYPE_STR) ? int'(cur_len) : 4);
        if ($urandom_range(0, 4) != 0) len = need + $urandom_range(0, 3);
        else len = $urandom_range(1, (need > 1) ? need : 1);
        if (len < 1) len = 1;
        send_record(len, $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
    endtask

    initial begin
        int sent;
        int len;
        logic [1:0] ft;
        logic [7:0] fl;
        logic [11:0] fo;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: integer at offset 0, always true
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hff, 1'b1, 1'b1);
        for (int j = 0; j < 4; j++) send_byte(8'hff, 1'b0, j == 3);
        for (int j = 0; j < 4; j++) send_byte(8'h00, 1'b1, j == 3);
        for (int j = 0; j < 5; j++) send_byte(8'h5a, logic'(j % 2), j == 4);

        for (int p = 1; p <= 16; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 54; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 54; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            ft = 2'(p % 4);
            fo = 12'($urandom_range(0, 10));
            fl = 8'($urandom_range(0, 20));
            case (p)
                1: configure(TYPE_STR, OP_EQ, '0, 8'd255,
                             {$urandom | 32'h0101_0101, $urandom | 32'h0101_0101,
                              $urandom | 32'h0101_0101, $urandom | 32'h0101_0101});
                // attribute at the last tracked byte, records run past the bound
                3: configure(TYPE_STR, OP_GE, 12'd4095, 8'd1, pick_value(TYPE_STR));
                4: configure(TYPE_STR, 3'($urandom_range(0, 5)), fo, 8'd0,
                             pick_value(TYPE_STR));
                5: configure(2'd3, 3'd7, fo, fl, pick_value(TYPE_INT));
                9: configure(TYPE_FLOAT, OP_NE, fo, fl, {96'd0, 32'h7fc0_0001});
                default: configure(ft, 3'($urandom_range(0, 7)), fo, fl, pick_value(ft));
            endcase
            if (p == 5) hold_req = 1'b1;
            sent = 0;
            while (sent < 140) begin
                random_record(len);
                sent += len;
                // let every result come back before going on
                if (p == 6 && sent >= 70 && sent - len < 70) begin
                    @(negedge i_clk);
                    s_axis_tvalid = 1'b0;
                    wait (pending == 0);
                end
            end
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        wait (pending == 0);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
